// ===== hdl/olist_pkg.sv =====
// -----------------------------------------------------------------------------
// Ordered list engine package
// Sizes, operation codes, and the command and status words between the
// controller and the datapath.
// -----------------------------------------------------------------------------
package olist_pkg;

  localparam int DEPTH     = 64;
  localparam int ITEM_W    = 32;
  localparam int IDX_W     = $clog2(DEPTH);
  localparam int CNT_W     = IDX_W + 1;

  localparam int ACTION_W  = 4;
  localparam int INDEX_W   = 7;
  localparam int INDEX_B_W = 6;
  localparam int COUNT_W   = 7;
  localparam int VALUE_W   = 32;
  localparam int FOUND_W   = 7;

  localparam logic [FOUND_W-1:0] NO_INDEX = {FOUND_W{1'b1}};

  typedef logic [ITEM_W-1:0] item_t;
  typedef logic [IDX_W-1:0]  addr_t;
  typedef logic [CNT_W-1:0]  cnt_t;

  typedef enum logic [ACTION_W-1:0] {
    OP_APPEND     = 4'd0,
    OP_INSERT     = 4'd1,
    OP_REMOVE_AT  = 4'd2,
    OP_REMOVE_VAL = 4'd3,
    OP_REMOVE_RNG = 4'd4,
    OP_REPLACE    = 4'd5,
    OP_SWAP       = 4'd6,
    OP_MOVE       = 4'd7,
    OP_READ       = 4'd8,
    OP_FIND       = 4'd9,
    OP_CLEAR      = 4'd10
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_TAKE,
    ST_SWAP,
    ST_COPY,
    ST_PUT,
    ST_SCAN,
    ST_FINISH
  } state_e;

  typedef enum logic [2:0] {
    SU_NONE,
    SU_INS,
    SU_DEL,
    SU_DELPOS,
    SU_RNG,
    SU_MV,
    SU_SCAN
  } setup_e;

  typedef enum logic [1:0] {
    RD_NONE,
    RD_IA,
    RD_IB
  } rd_e;

  typedef enum logic [2:0] {
    WR_NONE,
    WR_CNT_VAL,
    WR_IA_VAL,
    WR_IA_RD,
    WR_IB_TMP
  } wr_e;

  typedef enum logic [2:0] {
    CNT_HOLD,
    CNT_INC,
    CNT_SUB1,
    CNT_SUBN,
    CNT_CLR
  } cnt_e;

  typedef struct packed {
    logic   cap;
    setup_e setup;
    rd_e    rd;
    wr_e    wr;
    cnt_e   cnt;
    logic   copy_run;
    logic   scan_run;
    logic   tmp_ld;
    logic   item_ld;
    logic   found_ld;
    logic   ok_set;
    logic   res_ld;
  } cmd_t;

  typedef struct packed {
    op_e  action;
    logic full;
    logic ia_le_cnt;
    logic ia_lt_cnt;
    logic ib_lt_cnt;
    logic range_ok;
    logic copy_last;
    logic scan_hit;
    logic scan_end;
  } sts_t;

endpackage

// ===== hdl/olist_dp.sv =====
// -----------------------------------------------------------------------------
// Ordered list datapath
// List memory, live count, copy and scan address counters, result registers.
// -----------------------------------------------------------------------------
module olist_dp (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  olist_pkg::cmd_t                       cmd_i,
  output olist_pkg::sts_t                       sts_o,
  input  logic [olist_pkg::ACTION_W-1:0]        action_i,
  input  logic [olist_pkg::INDEX_W-1:0]         index_i,
  input  logic [olist_pkg::INDEX_B_W-1:0]       index_b_i,
  input  logic [olist_pkg::COUNT_W-1:0]         count_i,
  input  logic [olist_pkg::VALUE_W-1:0]         value_i,
  output logic                                  ok_o,
  output logic [olist_pkg::VALUE_W-1:0]         item_value_o,
  output logic signed [olist_pkg::FOUND_W-1:0]  found_index_o,
  output logic [olist_pkg::COUNT_W-1:0]         item_count_o
);
  import olist_pkg::*;

  item_t               mem_q [DEPTH];
  item_t               rdata_q;
  item_t               tmp_q;
  item_t               val_q;
  item_t               item_q;
  op_e                 action_q;
  cnt_t                ia_q;
  addr_t               ib_q;
  cnt_t                rcnt_q;
  cnt_t                count_q, count_d;
  cnt_t                ra_q, ra_d;
  addr_t               wa_q, wa_d;
  cnt_t                len_q, len_d;
  logic                dir_q, dir_d;
  logic                pend_q, pend_d;
  logic                ok_q;
  logic [FOUND_W-1:0]  found_q;
  logic                res_ok_q;
  item_t               res_item_q;
  logic [FOUND_W-1:0]  res_found_q;
  cnt_t                res_count_q;

  logic                mem_we, mem_re;
  addr_t               waddr, raddr;
  item_t               wdata;
  cnt_t                rem, clip_n, wa_ext;
  logic                ia_lt_ib;

  assign rem      = count_q - ia_q;
  assign clip_n   = (rcnt_q > rem) ? rem : rcnt_q;
  assign ia_lt_ib = ia_q < {1'b0, ib_q};
  assign wa_ext   = {1'b0, wa_q};

  always_comb begin
    sts_o.action    = action_q;
    sts_o.full      = count_q == CNT_W'(DEPTH);
    sts_o.ia_le_cnt = ia_q <= count_q;
    sts_o.ia_lt_cnt = ia_q < count_q;
    sts_o.ib_lt_cnt = {1'b0, ib_q} < count_q;
    sts_o.range_ok  = (ia_q <= count_q) && (clip_n != '0);
    sts_o.copy_last = len_q == '0;
    sts_o.scan_hit  = pend_q && (rdata_q == val_q);
    sts_o.scan_end  = !pend_q && (ra_q >= count_q);
  end

  always_comb begin
    mem_re = 1'b0;
    raddr  = ra_q[IDX_W-1:0];
    unique case (cmd_i.rd)
      RD_IA: begin
        mem_re = 1'b1;
        raddr  = ia_q[IDX_W-1:0];
      end
      RD_IB: begin
        mem_re = 1'b1;
        raddr  = ib_q;
      end
      default: ;
    endcase
    if (cmd_i.copy_run && len_q != '0) begin
      mem_re = 1'b1;
    end
    if (cmd_i.scan_run && ra_q < count_q) begin
      mem_re = 1'b1;
    end
  end

  always_comb begin
    mem_we = 1'b0;
    waddr  = wa_q;
    wdata  = rdata_q;
    unique case (cmd_i.wr)
      WR_CNT_VAL: begin
        mem_we = 1'b1;
        waddr  = count_q[IDX_W-1:0];
        wdata  = val_q;
      end
      WR_IA_VAL: begin
        mem_we = 1'b1;
        waddr  = ia_q[IDX_W-1:0];
        wdata  = val_q;
      end
      WR_IA_RD: begin
        mem_we = 1'b1;
        waddr  = ia_q[IDX_W-1:0];
      end
      WR_IB_TMP: begin
        mem_we = 1'b1;
        waddr  = ib_q;
        wdata  = tmp_q;
      end
      default: ;
    endcase
    if (cmd_i.copy_run && pend_q) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[waddr] <= wdata;
    end
    if (mem_re) begin
      rdata_q <= mem_q[raddr];
    end
  end

  always_comb begin
    ra_d   = ra_q;
    wa_d   = wa_q;
    len_d  = len_q;
    dir_d  = dir_q;
    pend_d = 1'b0;
    if (cmd_i.copy_run) begin
      if (len_q != '0) begin
        pend_d = 1'b1;
        ra_d   = dir_q ? ra_q + CNT_W'(1) : ra_q - CNT_W'(1);
        len_d  = len_q - CNT_W'(1);
      end
      if (pend_q) begin
        wa_d = dir_q ? wa_q + IDX_W'(1) : wa_q - IDX_W'(1);
      end
    end
    if (cmd_i.scan_run && ra_q < count_q) begin
      pend_d = 1'b1;
      wa_d   = ra_q[IDX_W-1:0];
      ra_d   = ra_q + CNT_W'(1);
    end
    unique case (cmd_i.setup)
      SU_INS: begin
        ra_d  = count_q - CNT_W'(1);
        wa_d  = count_q[IDX_W-1:0];
        len_d = count_q - ia_q;
        dir_d = 1'b0;
      end
      SU_DEL: begin
        ra_d  = ia_q + CNT_W'(1);
        wa_d  = ia_q[IDX_W-1:0];
        len_d = count_q - ia_q - CNT_W'(1);
        dir_d = 1'b1;
      end
      SU_DELPOS: begin
        ra_d  = wa_ext + CNT_W'(1);
        len_d = count_q - wa_ext - CNT_W'(1);
        dir_d = 1'b1;
      end
      SU_RNG: begin
        ra_d  = ia_q + clip_n;
        wa_d  = ia_q[IDX_W-1:0];
        len_d = count_q - ia_q - clip_n;
        dir_d = 1'b1;
      end
      SU_MV: begin
        wa_d = ia_q[IDX_W-1:0];
        if (ia_lt_ib) begin
          ra_d  = ia_q + CNT_W'(1);
          len_d = {1'b0, ib_q} - ia_q;
          dir_d = 1'b1;
        end else begin
          ra_d  = ia_q - CNT_W'(1);
          len_d = ia_q - {1'b0, ib_q};
          dir_d = 1'b0;
        end
      end
      SU_SCAN: begin
        ra_d = '0;
      end
      default: ;
    endcase
    if (cmd_i.setup != SU_NONE) begin
      pend_d = 1'b0;
    end
  end

  always_comb begin
    unique case (cmd_i.cnt)
      CNT_INC:  count_d = count_q + CNT_W'(1);
      CNT_SUB1: count_d = count_q - CNT_W'(1);
      CNT_SUBN: count_d = count_q - clip_n;
      CNT_CLR:  count_d = '0;
      default:  count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      pend_q  <= 1'b0;
      len_q   <= '0;
    end else begin
      count_q <= count_d;
      pend_q  <= pend_d;
      len_q   <= len_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ra_q  <= ra_d;
    wa_q  <= wa_d;
    dir_q <= dir_d;
    if (cmd_i.cap) begin
      action_q <= op_e'(action_i);
      ia_q     <= index_i;
      ib_q     <= index_b_i;
      rcnt_q   <= count_i;
      val_q    <= value_i;
      ok_q     <= 1'b0;
      item_q   <= '0;
      found_q  <= NO_INDEX;
    end else begin
      if (cmd_i.ok_set) begin
        ok_q <= 1'b1;
      end
      if (cmd_i.item_ld) begin
        item_q <= rdata_q;
      end
      if (cmd_i.found_ld) begin
        found_q <= FOUND_W'(wa_q);
      end
    end
    if (cmd_i.tmp_ld) begin
      tmp_q <= rdata_q;
    end
    if (cmd_i.res_ld) begin
      res_ok_q    <= ok_q;
      res_item_q  <= item_q;
      res_found_q <= found_q;
      res_count_q <= count_q;
    end
  end

  assign ok_o          = res_ok_q;
  assign item_value_o  = res_item_q;
  assign found_index_o = res_found_q;
  assign item_count_o  = res_count_q;

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("live count beyond capacity");

  a_no_rw_collide: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_we && mem_re) |-> (waddr != raddr))
    else $error("read and write at the same address");

  a_pend_from_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> $past(mem_re))
    else $error("pending word without a read");
`endif

endmodule

// ===== hdl/olist_ctrl.sv =====
// -----------------------------------------------------------------------------
// Ordered list controller
// Sequences each operation over the datapath and runs the output handshake.
// -----------------------------------------------------------------------------
module olist_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  input  olist_pkg::sts_t  sts_i,
  output olist_pkg::cmd_t  cmd_o
);
  import olist_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.cap = 1'b1;
          state_d   = ST_DECODE;
        end
      end
      ST_DECODE: begin
        state_d = ST_FINISH;
        unique case (sts_i.action)
          OP_APPEND: begin
            if (!sts_i.full) begin
              cmd_o.wr     = WR_CNT_VAL;
              cmd_o.cnt    = CNT_INC;
              cmd_o.ok_set = 1'b1;
            end
          end
          OP_INSERT: begin
            if (!sts_i.full && sts_i.ia_le_cnt) begin
              cmd_o.setup = SU_INS;
              state_d     = ST_COPY;
            end
          end
          OP_REMOVE_AT, OP_READ: begin
            if (sts_i.ia_lt_cnt) begin
              cmd_o.rd = RD_IA;
              state_d  = ST_TAKE;
            end
          end
          OP_SWAP, OP_MOVE: begin
            if (sts_i.ia_lt_cnt && sts_i.ib_lt_cnt) begin
              cmd_o.rd = RD_IA;
              state_d  = ST_TAKE;
            end
          end
          OP_REMOVE_VAL, OP_FIND: begin
            cmd_o.setup = SU_SCAN;
            state_d     = ST_SCAN;
          end
          OP_REMOVE_RNG: begin
            if (sts_i.range_ok) begin
              cmd_o.setup  = SU_RNG;
              cmd_o.cnt    = CNT_SUBN;
              cmd_o.ok_set = 1'b1;
              state_d      = ST_COPY;
            end
          end
          OP_REPLACE: begin
            if (sts_i.ia_lt_cnt) begin
              cmd_o.wr     = WR_IA_VAL;
              cmd_o.ok_set = 1'b1;
            end
          end
          OP_CLEAR: begin
            cmd_o.cnt    = CNT_CLR;
            cmd_o.ok_set = 1'b1;
          end
          default: ;
        endcase
      end
      ST_TAKE: begin
        unique case (sts_i.action)
          OP_REMOVE_AT: begin
            cmd_o.item_ld = 1'b1;
            cmd_o.setup   = SU_DEL;
            cmd_o.cnt     = CNT_SUB1;
            cmd_o.ok_set  = 1'b1;
            state_d       = ST_COPY;
          end
          OP_READ: begin
            cmd_o.item_ld = 1'b1;
            cmd_o.ok_set  = 1'b1;
            state_d       = ST_FINISH;
          end
          OP_SWAP: begin
            cmd_o.tmp_ld = 1'b1;
            cmd_o.rd     = RD_IB;
            state_d      = ST_SWAP;
          end
          OP_MOVE: begin
            cmd_o.tmp_ld = 1'b1;
            cmd_o.setup  = SU_MV;
            state_d      = ST_COPY;
          end
          default: state_d = ST_FINISH;
        endcase
      end
      ST_SWAP: begin
        cmd_o.wr = WR_IA_RD;
        state_d  = ST_PUT;
      end
      ST_COPY: begin
        cmd_o.copy_run = 1'b1;
        if (sts_i.copy_last) begin
          if (sts_i.action == OP_INSERT || sts_i.action == OP_MOVE) begin
            state_d = ST_PUT;
          end else begin
            state_d = ST_FINISH;
          end
        end
      end
      ST_PUT: begin
        if (sts_i.action == OP_INSERT) begin
          cmd_o.wr  = WR_IA_VAL;
          cmd_o.cnt = CNT_INC;
        end else begin
          cmd_o.wr = WR_IB_TMP;
        end
        cmd_o.ok_set = 1'b1;
        state_d      = ST_FINISH;
      end
      ST_SCAN: begin
        priority if (sts_i.scan_hit) begin
          cmd_o.ok_set = 1'b1;
          if (sts_i.action == OP_REMOVE_VAL) begin
            cmd_o.item_ld = 1'b1;
            cmd_o.setup   = SU_DELPOS;
            cmd_o.cnt     = CNT_SUB1;
            state_d       = ST_COPY;
          end else begin
            cmd_o.found_ld = 1'b1;
            state_d        = ST_FINISH;
          end
        end else if (sts_i.scan_end) begin
          state_d = ST_FINISH;
        end else begin
          cmd_o.scan_run = 1'b1;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          cmd_o.res_ld = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    if (cmd_o.res_ld) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

`ifndef SYNTHESIS
  a_res_ld_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.res_ld |-> out_free)
    else $error("result loaded over a word not yet taken");

  a_accept_decode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == ST_DECODE))
    else $error("accepted word not decoded");

  a_out_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(out_valid_q) |-> $past(out_ready_i))
    else $error("result dropped before it was taken");
`endif

endmodule

// ===== hdl/ordered_list_engine_unit.sv =====
// -----------------------------------------------------------------------------
// Ordered list engine
// Fixed-capacity ordered list with append, insert, remove, replace, swap,
// move, read, find and clear, one result word per input word.
//
// Channel  Handshake                   Payload
// in       in_valid_i / in_ready_o     action_i index_i index_b_i count_i value_i
// out      out_valid_o / out_ready_i   ok_o item_value_o found_index_o item_count_o
//
// Append, replace, clear and words rejected at decode complete in the decode state; read
// adds a take state, and swap adds take, swap and put states. Insert, remove at an index,
// range removal and move shift the words in the copy state, one word per cycle through
// the single read and single write port of the list memory.
// Find and remove by value scan the list from index 0 until a match or the end.
// Reset clears the live count only; the list memory has no clearing pass.
// A result waits in the output register while the next word is accepted.
// -----------------------------------------------------------------------------
module ordered_list_engine_unit (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic [olist_pkg::ACTION_W-1:0]        action_i,
  input  logic [olist_pkg::INDEX_W-1:0]         index_i,
  input  logic [olist_pkg::INDEX_B_W-1:0]       index_b_i,
  input  logic [olist_pkg::COUNT_W-1:0]         count_i,
  input  logic [olist_pkg::VALUE_W-1:0]         value_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic                                  ok_o,
  output logic [olist_pkg::VALUE_W-1:0]         item_value_o,
  output logic signed [olist_pkg::FOUND_W-1:0]  found_index_o,
  output logic [olist_pkg::COUNT_W-1:0]         item_count_o
);
  import olist_pkg::*;

  cmd_t cmd;
  sts_t sts;

  olist_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  olist_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .action_i      (action_i),
    .index_i       (index_i),
    .index_b_i     (index_b_i),
    .count_i       (count_i),
    .value_i       (value_i),
    .ok_o          (ok_o),
    .item_value_o  (item_value_o),
    .found_index_o (found_index_o),
    .item_count_o  (item_count_o)
  );

endmodule

// ===== bench/olist_result_checker.sv =====
// -----------------------------------------------------------------------------
// Ordered list engine result checker
// Watches the input and output channels of the engine and keeps its own copy
// of the list. Each accepted input word is applied to that copy and the
// predicted result is queued. Each accepted result word is compared field by
// field with the oldest queued prediction.
// -----------------------------------------------------------------------------
module olist_result_checker (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  input  logic                                  in_ready_i,
  input  logic [olist_pkg::ACTION_W-1:0]        action_i,
  input  logic [olist_pkg::INDEX_W-1:0]         index_i,
  input  logic [olist_pkg::INDEX_B_W-1:0]       index_b_i,
  input  logic [olist_pkg::COUNT_W-1:0]         count_i,
  input  logic [olist_pkg::VALUE_W-1:0]         value_i,
  input  logic                                  out_valid_i,
  input  logic                                  out_ready_i,
  input  logic                                  ok_i,
  input  logic [olist_pkg::VALUE_W-1:0]         item_value_i,
  input  logic signed [olist_pkg::FOUND_W-1:0]  found_index_i,
  input  logic [olist_pkg::COUNT_W-1:0]         item_count_i,
  output int                                    mismatch_count_o,
  output int                                    pending_o,
  output int                                    fill_o,
  output int                                    checked_o,
  output int                                    peak_fill_o,
  output int                                    rejected_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import olist_pkg::*;

  typedef struct packed {
    logic                 ok;
    logic [VALUE_W-1:0]   item;
    logic [FOUND_W-1:0]   found;
    logic [COUNT_W-1:0]   len;
  } list_result_t;

  logic [ITEM_W-1:0] list_mem [DEPTH];
  int                list_len   = 0;
  int                mismatches = 0;
  int                checked    = 0;
  int                peak_fill  = 0;
  int                rejected   = 0;
  list_result_t      expected_results [$];
  list_result_t      want;
  list_result_t      got;

  function automatic int first_index_of(logic [ITEM_W-1:0] val);
    for (int i = 0; i < list_len; i++) begin
      if (list_mem[i] == val) return i;
    end
    return -1;
  endfunction

  function automatic void drop_entries(int at, int n);
    for (int i = at; i + n < list_len; i++) begin
      list_mem[i] = list_mem[i + n];
    end
    list_len -= n;
  endfunction

  function automatic list_result_t apply_list_op(
    logic [ACTION_W-1:0] act,
    logic [INDEX_W-1:0]  ia,
    logic [INDEX_B_W-1:0] ib,
    logic [COUNT_W-1:0]  cnt,
    logic [VALUE_W-1:0]  val
  );
    list_result_t    r;
    int              a;
    int              b;
    int              n;
    int              pos;
    logic [ITEM_W-1:0] held;
    a = ia;
    b = ib;
    n = cnt;
    r.ok = 1'b0;
    r.item = '0;
    r.found = NO_INDEX;
    case (op_e'(act))
      OP_APPEND: begin
        if (list_len < DEPTH) begin
          list_mem[list_len] = val;
          list_len++;
          r.ok = 1'b1;
        end
      end
      OP_INSERT: begin
        if (list_len < DEPTH && a <= list_len) begin
          for (int i = list_len; i > a; i--) list_mem[i] = list_mem[i - 1];
          list_mem[a] = val;
          list_len++;
          r.ok = 1'b1;
        end
      end
      OP_REMOVE_AT: begin
        if (a < list_len) begin
          r.item = list_mem[a];
          drop_entries(a, 1);
          r.ok = 1'b1;
        end
      end
      OP_REMOVE_VAL: begin
        pos = first_index_of(val);
        if (pos >= 0) begin
          r.item = list_mem[pos];
          drop_entries(pos, 1);
          r.ok = 1'b1;
        end
      end
      OP_REMOVE_RNG: begin
        if (a <= list_len) begin
          if (n > list_len - a) n = list_len - a;
          if (n > 0) begin
            drop_entries(a, n);
            r.ok = 1'b1;
          end
        end
      end
      OP_REPLACE: begin
        if (a < list_len) begin
          list_mem[a] = val;
          r.ok = 1'b1;
        end
      end
      OP_SWAP: begin
        if (a < list_len && b < list_len) begin
          held = list_mem[a];
          list_mem[a] = list_mem[b];
          list_mem[b] = held;
          r.ok = 1'b1;
        end
      end
      OP_MOVE: begin
        if (a < list_len && b < list_len) begin
          held = list_mem[a];
          if (a < b) begin
            for (int i = a; i < b; i++) list_mem[i] = list_mem[i + 1];
          end else begin
            for (int i = a; i > b; i--) list_mem[i] = list_mem[i - 1];
          end
          list_mem[b] = held;
          r.ok = 1'b1;
        end
      end
      OP_READ: begin
        if (a < list_len) begin
          r.item = list_mem[a];
          r.ok = 1'b1;
        end
      end
      OP_FIND: begin
        pos = first_index_of(val);
        if (pos >= 0) begin
          r.found = pos[FOUND_W-1:0];
          r.ok = 1'b1;
        end
      end
      OP_CLEAR: begin
        list_len = 0;
        r.ok = 1'b1;
      end
      default: begin
      end
    endcase
    r.len = list_len[COUNT_W-1:0];
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      list_len = 0;
      expected_results.delete();
    end else begin
      if (out_valid_i && out_ready_i) begin
        got = '{ok_i, item_value_i, found_index_i, item_count_i};
        checked++;
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: result word with nothing pending: ok=%0b item=%h found=%h count=%0d",
                     $realtime, got.ok, got.item, got.found, got.len);
        end else begin
          want = expected_results.pop_front();
          if (got.ok !== want.ok || got.item !== want.item ||
              got.found !== want.found || got.len !== want.len) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: mismatch: expected ok=%0b item=%h found=%h count=%0d, got ok=%0b item=%h found=%h count=%0d",
                       $realtime, want.ok, want.item, want.found, want.len,
                       got.ok, got.item, got.found, got.len);
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        want = apply_list_op(action_i, index_i, index_b_i, count_i, value_i);
        expected_results.push_back(want);
        if (!want.ok) rejected++;
        if (list_len > peak_fill) peak_fill = list_len;
      end
    end
    mismatch_count_o <= mismatches;
    pending_o        <= expected_results.size();
    fill_o           <= list_len;
    checked_o        <= checked;
    peak_fill_o      <= peak_fill;
    rejected_o       <= rejected;
  end

endmodule

// ===== bench/ordered_list_engine_unit_test.sv =====
// -----------------------------------------------------------------------------
// Ordered list engine testbench
// Drives a short directed sequence through every operation and edge case,
// then about fourteen hundred random words in phases that grow, churn and
// shrink the list, with random gaps on both channels and one long receiver
// stall. A separate checker predicts and compares every result word.
// -----------------------------------------------------------------------------
module ordered_list_engine_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import olist_pkg::*;

  localparam int LIMIT_CYCLES    = 1_000_000;
  localparam int RANDOM_WORDS    = 1425;
  localparam int SEGMENT_WORDS   = 100;
  localparam int HOLD_OFF_AT     = 500;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int DRAIN_CYCLES    = 200;

  localparam logic [ACTION_W-1:0] ACT_UNUSED_LO = 4'd11;
  localparam logic [ACTION_W-1:0] ACT_UNUSED_HI = 4'd15;

  typedef enum int {
    MIX_GROW,
    MIX_EVEN,
    MIX_SHRINK
  } mix_e;

  logic                        clk;
  logic                        rst_n;
  logic                        in_valid;
  logic                        in_ready;
  logic [ACTION_W-1:0]         action;
  logic [INDEX_W-1:0]          index;
  logic [INDEX_B_W-1:0]        index_b;
  logic [COUNT_W-1:0]          count;
  logic [VALUE_W-1:0]          value;
  logic                        out_valid;
  logic                        out_ready;
  logic                        ok;
  logic [VALUE_W-1:0]          item_value;
  logic signed [FOUND_W-1:0]   found_index;
  logic [COUNT_W-1:0]          item_count;

  int   mismatch_count;
  int   pending;
  int   fill;
  int   checked;
  int   peak_fill;
  int   rejected;
  int   cycles = 0;
  logic sender_burst = 1'b0;

  ordered_list_engine_unit dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .action_i      (action),
    .index_i       (index),
    .index_b_i     (index_b),
    .count_i       (count),
    .value_i       (value),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .ok_o          (ok),
    .item_value_o  (item_value),
    .found_index_o (found_index),
    .item_count_o  (item_count)
  );

  olist_result_checker u_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_ready_i       (in_ready),
    .action_i         (action),
    .index_i          (index),
    .index_b_i        (index_b),
    .count_i          (count),
    .value_i          (value),
    .out_valid_i      (out_valid),
    .out_ready_i      (out_ready),
    .ok_i             (ok),
    .item_value_i     (item_value),
    .found_index_i    (found_index),
    .item_count_i     (item_count),
    .mismatch_count_o (mismatch_count),
    .pending_o        (pending),
    .fill_o           (fill),
    .checked_o        (checked),
    .peak_fill_o      (peak_fill),
    .rejected_o       (rejected)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= LIMIT_CYCLES) begin
      $display("Run stopped at the cycle limit with %0d result words pending", pending);
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic send_word(
    input logic [ACTION_W-1:0]  act,
    input logic [INDEX_W-1:0]   ia,
    input logic [INDEX_B_W-1:0] ib,
    input logic [COUNT_W-1:0]   cnt,
    input logic [VALUE_W-1:0]   val
  );
    int gap;
    gap = sender_burst ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    action   <= act;
    index    <= ia;
    index_b  <= ib;
    count    <= cnt;
    value    <= val;
    in_valid <= 1'b1;
    do @(posedge clk); while (!(in_valid && in_ready));
  endtask

  function automatic logic [ACTION_W-1:0] pick_action(mix_e mix);
    op_e ops [11] = '{OP_APPEND, OP_INSERT, OP_REMOVE_AT, OP_REMOVE_VAL, OP_REMOVE_RNG,
                      OP_REPLACE, OP_SWAP, OP_MOVE, OP_READ, OP_FIND, OP_CLEAR};
    int  w [12];
    int  total;
    int  roll;
    int  acc;
    case (mix)
      MIX_GROW:   w = '{30, 25, 5, 5, 2, 7, 6, 8, 5, 6, 0, 1};
      MIX_SHRINK: w = '{6, 4, 18, 16, 8, 6, 6, 8, 8, 10, 2, 1};
      default:    w = '{14, 12, 12, 10, 4, 8, 8, 10, 8, 10, 2, 2};
    endcase
    total = 0;
    foreach (w[i]) total += w[i];
    roll = $urandom_range(0, total - 1);
    acc = 0;
    for (int i = 0; i < 11; i++) begin
      acc += w[i];
      if (roll < acc) return ops[i];
    end
    return ACTION_W'($urandom_range(ACT_UNUSED_LO, ACT_UNUSED_HI));
  endfunction

  initial begin
    int   taken;
    int   gap;
    logic held_off;
    taken = 0;
    held_off = 1'b0;
    out_ready <= 1'b0;
    @(posedge rst_n);
    forever begin
      if (!held_off && taken >= HOLD_OFF_AT) begin
        gap = HOLD_OFF_CYCLES;
        held_off = 1'b1;
      end else if ((taken / 150) % 4 == 2) begin
        gap = 0;
      end else begin
        gap = $urandom_range(0, 9);
      end
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
      taken++;
    end
  end

  initial begin
    logic [ACTION_W-1:0]  act;
    logic [INDEX_W-1:0]   ia;
    logic [INDEX_B_W-1:0] ib;
    logic [COUNT_W-1:0]   cnt;
    logic [VALUE_W-1:0]   val;
    mix_e                 mix;
    int                   seg;

    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    action   <= OP_READ;
    index    <= '0;
    index_b  <= '0;
    count    <= '0;
    value    <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_word(OP_READ,       0,  0,  0, 32'h0);
    send_word(OP_REMOVE_AT,  0,  0,  0, 32'h0);
    send_word(OP_REMOVE_RNG, 0,  0,  0, 32'h0);
    send_word(OP_APPEND,     0,  0,  0, 32'h0000_0000);
    send_word(OP_APPEND,     0,  0,  0, 32'hFFFF_FFFF);
    send_word(OP_INSERT,     2,  0,  0, 32'hA5A5_A5A5);
    send_word(OP_INSERT,     0,  0,  0, 32'h5A5A_5A5A);
    send_word(OP_INSERT,     5,  0,  0, 32'h1234_5678);
    send_word(OP_FIND,       0,  0,  0, 32'hFFFF_FFFF);
    send_word(OP_FIND,       0,  0,  0, 32'h0BAD_F00D);
    send_word(OP_SWAP,       0,  3,  0, 32'h0);
    send_word(OP_SWAP,       0, 63,  0, 32'h0);
    send_word(OP_MOVE,       0,  3,  0, 32'h0);
    send_word(OP_MOVE,       3,  0,  0, 32'h0);
    send_word(OP_MOVE,       2,  2,  0, 32'h0);
    send_word(OP_REPLACE,    1,  0,  0, 32'h8000_0001);
    send_word(OP_REPLACE,   64,  0,  0, 32'h7FFF_FFFE);
    send_word(OP_REMOVE_VAL, 0,  0,  0, 32'hFFFF_FFFF);
    send_word(OP_REMOVE_VAL, 0,  0,  0, 32'h0BAD_F00D);
    send_word(OP_REMOVE_RNG, 3,  0,  5, 32'h0);
    send_word(OP_REMOVE_RNG, 1,  0, 64, 32'h0);
    send_word(ACT_UNUSED_LO, 0,  0,  0, 32'h0);
    send_word(ACT_UNUSED_HI, 0,  0,  0, 32'h0);
    send_word(OP_REMOVE_AT,  0,  0,  0, 32'h0);
    send_word(OP_CLEAR,      0,  0,  0, 32'h0);

    for (int w = 0; w < RANDOM_WORDS; w++) begin
      seg = w / SEGMENT_WORDS;
      mix = mix_e'(seg % 3);
      sender_burst = (seg % 4 == 1);
      act = pick_action(mix);
      ia  = INDEX_W'(($urandom_range(0, 9) < 7) ? $urandom_range(0, fill)
                                                : $urandom_range(0, 64));
      ib  = INDEX_B_W'(($urandom_range(0, 9) < 7) ? $urandom_range(0, (fill > 0) ? fill - 1 : 0)
                                                  : $urandom_range(0, 63));
      cnt = COUNT_W'(($urandom_range(0, 9) < 7) ? $urandom_range(1, 4)
                                                : $urandom_range(0, 64));
      val = ($urandom_range(0, 3) != 0) ? 32'h1111_1111 * $urandom_range(0, 15) : $urandom;
      send_word(act, ia, ib, cnt, val);
    end
    in_valid <= 1'b0;

    do @(posedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Checked %0d result words from %0d input words; %0d operations rejected.",
             checked, RANDOM_WORDS + 25, rejected);
    $display("List fill peaked at %0d of %0d entries; receiver stalled once for %0d cycles.",
             peak_fill, DEPTH, HOLD_OFF_CYCLES);
    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== ordered_list_engine_unit.f =====
hdl/olist_pkg.sv
hdl/olist_dp.sv
hdl/olist_ctrl.sv
hdl/ordered_list_engine_unit.sv
bench/olist_result_checker.sv
bench/ordered_list_engine_unit_test.sv
